### sv/psmd_pkg.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder package
// Shared types, codes and sizes of the mouse packet decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package psmd_pkg;

	localparam int unsigned QueueDepthDefault = 2;

	localparam int unsigned AuxBit   = 5;
	localparam int unsigned SyncBit  = 3;
	localparam int unsigned XOvflBit = 6;
	localparam int unsigned YOvflBit = 7;
	localparam logic [7:0]  WheelNibbleMask = 8'h0F;

	typedef enum logic [1:0] {
		MT_STANDARD = 2'd0,
		MT_WHEEL    = 2'd1,
		MT_FIVE_BTN = 2'd2,
		MT_UNUSED   = 2'd3
	} mouse_type_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_X      = 2'd1,
		PH_Y      = 2'd2,
		PH_WHEEL  = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		EV_PRESS   = 2'd0,
		EV_RELEASE = 2'd1,
		EV_MOVE    = 2'd2,
		EV_SCROLL  = 2'd3
	} event_kind_t;

	// Event mask bits: press 1..3, release 1..3, move, scroll.
	typedef struct packed {
		logic        scroll;
		logic        move;
		logic [2:0]  release_btn;
		logic [2:0]  press_btn;
	} event_mask_t;

	typedef struct packed {
		event_mask_t       mask;
		logic [7:0]        delta_x;
		logic [8:0]        delta_y;
		logic [7:0]        scroll_amount;
	} packet_desc_t;

endpackage : psmd_pkg

`default_nettype wire

### sv/psmd_ifs.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder channels
// Valid/ready channels for received bytes and for decoded events.
// ----------------------------------------------------------------------------
`default_nettype none

interface psmd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ctrl_status;
	logic [7:0] rx_byte;

	modport source (output valid, output ctrl_status, output rx_byte, input ready);
	modport sink (input valid, input ctrl_status, input rx_byte, output ready);
endinterface : psmd_in_if

interface psmd_out_if;
	logic              valid;
	logic              ready;
	logic [1:0]        event_kind;
	logic [1:0]        button_number;
	logic signed [7:0] delta_x;
	logic signed [8:0] delta_y;
	logic signed [7:0] scroll_amount;
	logic              last_event;

	modport source (output valid, output event_kind, output button_number,
		output delta_x, output delta_y, output scroll_amount, output last_event,
		input ready);
	modport sink (input valid, input event_kind, input button_number,
		input delta_x, input delta_y, input scroll_amount, input last_event,
		output ready);
endinterface : psmd_out_if

`default_nettype wire

### sv/psmd_front.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder front end
// Accepts status and data bytes, assembles packets and queues a descriptor
// of the events that each completed packet causes, if it causes any.
// ----------------------------------------------------------------------------
`default_nettype none

module psmd_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      cfg_we,
	input  wire [1:0]                cfg_wdata,
	psmd_in_if.sink                  pkt_in,
	input  wire                      queue_full,
	output logic                     push,
	output psmd_pkg::packet_desc_t   push_desc
);

	psmd_pkg::mouse_type_t mouse_type_q;
	psmd_pkg::phase_t      phase_q, phase_nx;
	logic [7:0]            header_q, header_nx;
	logic [7:0]            prev_header_q, prev_header_nx;
	logic [7:0]            motion_x_q, motion_x_nx;
	logic [7:0]            motion_y_q, motion_y_nx;
	logic [7:0]            wheel_q, wheel_nx;
	logic                  accept;
	logic                  aux;
	logic                  done;

	assign pkt_in.ready = !queue_full;
	assign aux          = pkt_in.ctrl_status[psmd_pkg::AuxBit];
	assign accept       = pkt_in.valid && pkt_in.ready && aux;

	always_comb begin
		phase_nx = phase_q;
		case (phase_q)
			psmd_pkg::PH_HEADER: begin
				if (pkt_in.rx_byte[psmd_pkg::SyncBit]) begin
					phase_nx = psmd_pkg::PH_X;
				end
			end
			psmd_pkg::PH_X: phase_nx = psmd_pkg::PH_Y;
			psmd_pkg::PH_Y: begin
				phase_nx = (mouse_type_q != psmd_pkg::MT_STANDARD) ?
					psmd_pkg::PH_WHEEL : psmd_pkg::PH_HEADER;
			end
			default: phase_nx = psmd_pkg::PH_HEADER;
		endcase
	end

	always_comb begin
		header_nx      = header_q;
		prev_header_nx = prev_header_q;
		motion_x_nx    = motion_x_q;
		motion_y_nx    = motion_y_q;
		wheel_nx       = wheel_q;
		case (phase_q)
			psmd_pkg::PH_HEADER: begin
				prev_header_nx = header_q;
				if (pkt_in.rx_byte[psmd_pkg::SyncBit]) begin
					header_nx = pkt_in.rx_byte;
				end
			end
			psmd_pkg::PH_X: begin
				motion_x_nx = header_q[psmd_pkg::XOvflBit] ? 8'd0 : pkt_in.rx_byte;
			end
			psmd_pkg::PH_Y: begin
				motion_y_nx = header_q[psmd_pkg::YOvflBit] ? 8'd0 : pkt_in.rx_byte;
			end
			default: begin
				case (mouse_type_q)
					psmd_pkg::MT_WHEEL:    wheel_nx = pkt_in.rx_byte;
					psmd_pkg::MT_FIVE_BTN: wheel_nx = pkt_in.rx_byte & psmd_pkg::WheelNibbleMask;
					default:               wheel_nx = wheel_q;
				endcase
			end
		endcase
	end

	always_comb begin
		done = (phase_nx == psmd_pkg::PH_HEADER) &&
			((phase_q == psmd_pkg::PH_Y) || (phase_q == psmd_pkg::PH_WHEEL));
		push_desc.mask.press_btn   = ~prev_header_nx[2:0] & header_nx[2:0];
		push_desc.mask.release_btn = prev_header_nx[2:0] & ~header_nx[2:0];
		push_desc.mask.move        = (motion_x_nx != 8'd0) || (motion_y_nx != 8'd0);
		push_desc.mask.scroll      = (wheel_nx != 8'd0);
		push_desc.delta_x          = motion_x_nx;
		push_desc.delta_y          = 9'(-{motion_y_nx[7], motion_y_nx});
		push_desc.scroll_amount    = wheel_nx;
		push = accept && done && (push_desc.mask != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mouse_type_q  <= psmd_pkg::MT_STANDARD;
			phase_q       <= psmd_pkg::PH_HEADER;
			header_q      <= 8'd0;
			prev_header_q <= 8'd0;
			motion_x_q    <= 8'd0;
			motion_y_q    <= 8'd0;
			wheel_q       <= 8'd0;
		end else begin
			if (cfg_we) begin
				mouse_type_q <= psmd_pkg::mouse_type_t'(cfg_wdata);
			end
			if (accept) begin
				phase_q       <= phase_nx;
				header_q      <= header_nx;
				prev_header_q <= prev_header_nx;
				motion_x_q    <= motion_x_nx;
				motion_y_q    <= motion_y_nx;
				wheel_q       <= wheel_nx;
			end
		end
	end

endmodule : psmd_front

`default_nettype wire

### sv/psmd_queue.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder descriptor queue
// A short first-in first-out queue of packet descriptors between the front
// and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module psmd_queue #(
	parameter int unsigned Depth = psmd_pkg::QueueDepthDefault
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      push,
	input  psmd_pkg::packet_desc_t   push_desc,
	output logic                     full,
	input  wire                      pop,
	output psmd_pkg::packet_desc_t   pop_desc,
	output logic                     empty
);

	localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CntW = $clog2(Depth + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

	psmd_pkg::packet_desc_t slot_q [Depth];
	logic [PtrW-1:0]        wr_ptr_q;
	logic [PtrW-1:0]        rd_ptr_q;
	logic [CntW-1:0]        count_q;
	logic                   do_push;
	logic                   do_pop;

	assign full     = (count_q == FullCnt);
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_desc = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule : psmd_queue

`default_nettype wire

### sv/psmd_back.sv
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder back end
// Takes packet descriptors from the queue and sends their events one beat
// at a time through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module psmd_back (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      queue_empty,
	input  psmd_pkg::packet_desc_t   pop_desc,
	output logic                     pop,
	psmd_out_if.source               evt_out
);

	logic [7:0]  mask_q;
	logic [7:0]  dx_q;
	logic [8:0]  dy_q;
	logic [7:0]  sc_q;
	logic        out_valid_q;
	logic [1:0]  kind_q;
	logic [1:0]  button_q;
	logic [7:0]  out_dx_q;
	logic [8:0]  out_dy_q;
	logic [7:0]  out_sc_q;
	logic        last_q;

	logic [7:0]  sel;
	logic [7:0]  rest;
	logic        emit;
	psmd_pkg::event_kind_t kind;
	logic [1:0]  button;

	assign sel  = mask_q & (~mask_q + 8'd1);
	assign rest = mask_q & ~sel;
	assign emit = (mask_q != 8'd0) && (!out_valid_q || evt_out.ready);
	assign pop  = (mask_q == 8'd0) && !queue_empty;

	always_comb begin
		case (sel)
			8'b0000_0001: begin kind = psmd_pkg::EV_PRESS;   button = 2'd1; end
			8'b0000_0010: begin kind = psmd_pkg::EV_PRESS;   button = 2'd2; end
			8'b0000_0100: begin kind = psmd_pkg::EV_PRESS;   button = 2'd3; end
			8'b0000_1000: begin kind = psmd_pkg::EV_RELEASE; button = 2'd1; end
			8'b0001_0000: begin kind = psmd_pkg::EV_RELEASE; button = 2'd2; end
			8'b0010_0000: begin kind = psmd_pkg::EV_RELEASE; button = 2'd3; end
			8'b0100_0000: begin kind = psmd_pkg::EV_MOVE;    button = 2'd0; end
			default:      begin kind = psmd_pkg::EV_SCROLL;  button = 2'd0; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				mask_q <= pop_desc.mask;
			end else if (emit) begin
				mask_q <= rest;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (evt_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dx_q <= pop_desc.delta_x;
			dy_q <= pop_desc.delta_y;
			sc_q <= pop_desc.scroll_amount;
		end
		if (emit) begin
			kind_q   <= kind;
			button_q <= button;
			out_dx_q <= (kind == psmd_pkg::EV_MOVE) ? dx_q : 8'd0;
			out_dy_q <= (kind == psmd_pkg::EV_MOVE) ? dy_q : 9'd0;
			out_sc_q <= (kind == psmd_pkg::EV_SCROLL) ? sc_q : 8'd0;
			last_q   <= (rest == 8'd0);
		end
	end

	assign evt_out.valid         = out_valid_q;
	assign evt_out.event_kind    = kind_q;
	assign evt_out.button_number = button_q;
	assign evt_out.delta_x       = out_dx_q;
	assign evt_out.delta_y       = out_dy_q;
	assign evt_out.scroll_amount = out_sc_q;
	assign evt_out.last_event    = last_q;

endmodule : psmd_back

`default_nettype wire

### sv/ps2_mouse_packet_decoder_unit.sv
// Events pass from the queue through the back end's mask register into the output register.
// Throughput: one byte per cycle while the descriptor queue has room; the back end sends
// one event per cycle unless evt_out stalls, and loads a descriptor once the previous is sent.
// The queue depth, QueueDepth packets, sets how far the front end may run ahead.
// Reset clears the packet state, the queue, the output valid flag and mouse_type (standard).
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder
// Assembles 3-byte and 4-byte mouse packets and reports button, motion and
// wheel events.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_decoder_unit #(
	parameter int unsigned QueueDepth = psmd_pkg::QueueDepthDefault
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_wdata,
	psmd_in_if.sink     pkt_in,
	psmd_out_if.source  evt_out
);

	logic                   push;
	logic                   pop;
	logic                   queue_full;
	logic                   queue_empty;
	psmd_pkg::packet_desc_t push_desc;
	psmd_pkg::packet_desc_t pop_desc;

	psmd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.pkt_in     (pkt_in),
		.queue_full (queue_full),
		.push       (push),
		.push_desc  (push_desc)
	);

	psmd_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (queue_full),
		.pop       (pop),
		.pop_desc  (pop_desc),
		.empty     (queue_empty)
	);

	psmd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.pop_desc    (pop_desc),
		.pop         (pop),
		.evt_out     (evt_out)
	);

endmodule : ps2_mouse_packet_decoder_unit

`default_nettype wire
